>>> sv/sdt_pkg.sv
// Package for the SDT service descriptor parser: constants, phase codes,
// configuration register indexes and the result record.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdt_pkg;

    // section size limits
    localparam int MAX_SECTION_BYTES = 1024;
    localparam int POS_W             = $clog2(MAX_SECTION_BYTES) + 1;
    localparam int SEC_LEN_W         = 12;
    localparam int LOOP_LEN_W        = 12;
    localparam int SECTION_HDR_BYTES = 3;
    localparam int CRC_BYTES         = 4;
    localparam logic [SEC_LEN_W-1:0] MIN_SECTION_LEN = SEC_LEN_W'(17);
    localparam logic [SEC_LEN_W-1:0] MAX_SECTION_LEN =
        SEC_LEN_W'(MAX_SECTION_BYTES - SECTION_HDR_BYTES);
    // distance from section_length to the first crc byte position
    localparam logic [SEC_LEN_W-1:0] CRC_BACKOFF =
        SEC_LEN_W'(CRC_BYTES - SECTION_HDR_BYTES);

    // fixed header byte positions
    localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TSID_HI   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TSID_LO   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(10);

    // service header byte offsets
    localparam logic [7:0] SVC_ID_HI   = 8'd0;
    localparam logic [7:0] SVC_ID_LO   = 8'd1;
    localparam logic [7:0] SVC_LOOP_HI = 8'd3;
    localparam logic [7:0] SVC_LOOP_LO = 8'd4;

    // descriptor codes
    localparam logic [7:0] TAG_SERVICE  = 8'h48;
    localparam logic [7:0] SVC_TYPE_DTV = 8'h01;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIVERY_SYSTEM = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TUNED_FREQUENCY = CFG_INDEX_W'(1);
    localparam int FREQ_W = 30;

    // parse phases, one-hot
    typedef enum logic [6:0] {
        PH_WAIT   = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_SVC    = 7'b0000100,
        PH_DTAG   = 7'b0001000,
        PH_DLEN   = 7'b0010000,
        PH_DBODY  = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // one result, service_number in the lowest bits
    typedef struct packed {
        logic              terrestrial;
        logic [FREQ_W-1:0] frequency;
        logic              stream_number_valid;
        logic [15:0]       stream_number;
        logic [15:0]       service_number;
    } sdt_result_t;

    localparam int RESULT_W = $bits(sdt_result_t);

    // configuration as seen by the parser
    typedef struct packed {
        logic              delivery_system;
        logic [FREQ_W-1:0] tuned_frequency;
    } sdt_cfg_t;

endpackage

`default_nettype wire

>>> sv/sdt_service_descriptor_parser_unit.sv
// Top level of the SDT service descriptor parser: configuration registers,
// parser and result buffer. Depends on sdt_pkg, sdt_parse, sdt_out_buffer.
//
// Usage:
//   s_ channel takes one SDT section byte per request (s_tdata), with
//   s_tuser high on the table id byte that opens a new section.
//   m_ channel gives one request per digital TV service descriptor found:
//   service id, transport stream id (non-terrestrial only), its valid flag, the
//   tuned frequency and the terrestrial flag, packed into 64 bits.
//   cfg_ channel writes delivery_system (index 0) and tuned_frequency
//   (index 1); other indexes are dropped. cfg_ready is always high; write
//   only while no byte is in flight.
//   Path: a byte is registered at the input and parsed from that register
//   once the result buffer has room; its result is registered in the buffer
//   and shown on m_ from there. Throughput: one byte per cycle while the buffer has room.
//   The input register and a two-entry result buffer hold the rate while
//   results wait; when m_tready stays low, both buffer entries fill and the
//   input register takes one more byte, then s_tready drops and no byte is lost.
//   Reset (aresetn low, synchronous) clears both registers to 0, empties the
//   buffer and puts the parser in the state waiting for a section start.
`default_nettype none

module sdt_service_descriptor_parser_unit
    import sdt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // section bytes
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] section_byte
    input  wire logic                   s_tuser,   // [0] section_start
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] service_number, [31:16] stream_number, [32] stream_number_valid,
    // [62:33] frequency, [63] terrestrial
    output logic [RESULT_W-1:0]         m_tdata,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    sdt_cfg_t    cfg_reg;
    sdt_result_t res;
    sdt_result_t out_data;
    logic        res_valid;
    logic        room;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DELIVERY_SYSTEM) begin
                cfg_reg.delivery_system <= cfg_data[0];
            end else if (cfg_index == CFG_TUNED_FREQUENCY) begin
                cfg_reg.tuned_frequency <= cfg_data[FREQ_W-1:0];
            end
        end
    end

    sdt_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg_reg),
        .room      (room),
        .res_valid (res_valid),
        .res       (res)
    );

    sdt_out_buffer u_out_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_data   (out_data)
    );

    assign m_tdata = out_data;

endmodule

`default_nettype wire

>>> sv/sdt_parse.sv
// Input register and single-pass section parser of the SDT block.
// Depends on sdt_pkg; emits at most one result per advanced byte.
`default_nettype none

module sdt_parse
    import sdt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // section_byte
    input  wire logic        s_tuser,    // section_start
    input  wire sdt_cfg_t    cfg,
    input  wire logic        room,
    output logic             res_valid,
    output sdt_result_t      res
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       advance;

    // parser state
    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [SEC_LEN_W-1:0]  sec_len_reg, sec_len_next;
    logic [15:0]           tsid_reg, tsid_next;
    logic [15:0]           svc_id_reg, svc_id_next;
    logic [LOOP_LEN_W-1:0] loop_left_reg, loop_left_next;
    logic [7:0]            fo_reg, fo_next;
    logic [7:0]            dlen_reg, dlen_next;
    logic                  tag_reg, tag_next;

    // values after a possible restart
    phase_t                cur_phase;
    logic [POS_W-1:0]      cur_pos;
    logic [SEC_LEN_W-1:0]  cur_sec_len;
    logic [15:0]           cur_tsid;
    logic [15:0]           cur_svc_id;
    logic [LOOP_LEN_W-1:0] cur_loop;
    logic [7:0]            cur_fo;
    logic [7:0]            cur_dlen;
    logic                  cur_tag;
    logic [LOOP_LEN_W-1:0] loop_dec;
    logic [LOOP_LEN_W-1:0] loop_svc;
    logic [SEC_LEN_W-1:0]  len_new;
    logic [7:0]            fo_inc;
    logic                  match;
    logic [7:0]            b;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign b        = in_byte_reg;

    // input register handshake
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // restart on section start
    always_comb begin
        if (in_start_reg) begin
            cur_phase   = PH_HEADER;
            cur_pos     = '0;
            cur_sec_len = '0;
            cur_tsid    = '0;
            cur_svc_id  = '0;
            cur_loop    = '0;
            cur_fo      = '0;
            cur_dlen    = '0;
            cur_tag     = 1'b0;
        end else begin
            cur_phase   = phase_reg;
            cur_pos     = pos_reg;
            cur_sec_len = sec_len_reg;
            cur_tsid    = tsid_reg;
            cur_svc_id  = svc_id_reg;
            cur_loop    = loop_left_reg;
            cur_fo      = fo_reg;
            cur_dlen    = dlen_reg;
            cur_tag     = tag_reg;
        end
    end

    // helpers
    assign loop_dec = (cur_loop != '0) ? cur_loop - LOOP_LEN_W'(1) : cur_loop;
    assign len_new  = {cur_sec_len[SEC_LEN_W-1:8], b};
    assign fo_inc   = cur_fo + 8'd1;

    // one byte of parsing
    always_comb begin
        phase_next     = cur_phase;
        pos_next       = cur_pos;
        sec_len_next   = cur_sec_len;
        tsid_next      = cur_tsid;
        svc_id_next    = cur_svc_id;
        loop_left_next = cur_loop;
        fo_next        = cur_fo;
        dlen_next      = cur_dlen;
        tag_next       = cur_tag;
        loop_svc       = cur_loop;
        match          = 1'b0;

        if (cur_phase != PH_WAIT && cur_phase != PH_DONE) begin
            pos_next = cur_pos + POS_W'(1);
            if (cur_phase == PH_HEADER) begin
                priority if (cur_pos == POS_LEN_HI) begin
                    sec_len_next = {b[3:0] & NIBBLE_MASK, 8'h00};
                end else if (cur_pos == POS_LEN_LO) begin
                    sec_len_next = len_new;
                    if (len_new < MIN_SECTION_LEN || len_new > MAX_SECTION_LEN) begin
                        phase_next = PH_WAIT;
                    end
                end else if (cur_pos == POS_TSID_HI) begin
                    tsid_next = {b, 8'h00};
                end else if (cur_pos == POS_TSID_LO) begin
                    tsid_next = {cur_tsid[15:8], b};
                end else if (cur_pos == POS_HDR_LAST) begin
                    phase_next = PH_SVC;
                    fo_next    = '0;
                end
            end else if (SEC_LEN_W'(cur_pos) >= cur_sec_len - CRC_BACKOFF) begin
                // crc and anything after it
                phase_next = PH_DONE;
            end else begin
                unique case (cur_phase)
                    PH_SVC: begin
                        priority if (cur_fo == SVC_ID_HI) begin
                            svc_id_next = {b, 8'h00};
                        end else if (cur_fo == SVC_ID_LO) begin
                            svc_id_next = {cur_svc_id[15:8], b};
                        end else if (cur_fo == SVC_LOOP_HI) begin
                            loop_svc = {b[3:0] & NIBBLE_MASK, 8'h00};
                        end else if (cur_fo == SVC_LOOP_LO) begin
                            loop_svc = {cur_loop[LOOP_LEN_W-1:8], b};
                        end else begin
                            loop_svc = cur_loop;
                        end
                        loop_left_next = loop_svc;
                        if (cur_fo >= SVC_LOOP_LO) begin
                            fo_next = '0;
                            if (loop_svc != '0) begin
                                phase_next = PH_DTAG;
                            end
                        end else begin
                            fo_next = fo_inc;
                        end
                    end
                    PH_DTAG: begin
                        tag_next       = (b == TAG_SERVICE);
                        loop_left_next = loop_dec;
                        if (loop_dec == '0) begin
                            phase_next = PH_SVC;
                            fo_next    = '0;
                        end else begin
                            phase_next = PH_DLEN;
                        end
                    end
                    PH_DLEN: begin
                        dlen_next      = b;
                        loop_left_next = loop_dec;
                        fo_next        = '0;
                        priority if (loop_dec == '0) begin
                            phase_next = PH_SVC;
                        end else if (b == 8'h00) begin
                            phase_next = PH_DTAG;
                        end else begin
                            phase_next = PH_DBODY;
                        end
                    end
                    PH_DBODY: begin
                        match          = (cur_fo == 8'h00) && cur_tag && (b == SVC_TYPE_DTV);
                        fo_next        = fo_inc;
                        loop_left_next = loop_dec;
                        priority if (loop_dec == '0) begin
                            phase_next = PH_SVC;
                            fo_next    = '0;
                        end else if (fo_inc >= cur_dlen) begin
                            phase_next = PH_DTAG;
                            fo_next    = '0;
                        end
                    end
                    default: begin
                        phase_next = cur_phase;
                    end
                endcase
            end
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            pos_reg       <= '0;
            sec_len_reg   <= '0;
            tsid_reg      <= '0;
            svc_id_reg    <= '0;
            loop_left_reg <= '0;
            fo_reg        <= '0;
            dlen_reg      <= '0;
            tag_reg       <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            sec_len_reg   <= sec_len_next;
            tsid_reg      <= tsid_next;
            svc_id_reg    <= svc_id_next;
            loop_left_reg <= loop_left_next;
            fo_reg        <= fo_next;
            dlen_reg      <= dlen_next;
            tag_reg       <= tag_next;
        end
    end

    // result record
    assign res_valid = advance && match;
    always_comb begin
        res.service_number      = cur_svc_id;
        res.stream_number       = cfg.delivery_system ? 16'h0000 : cur_tsid;
        res.stream_number_valid = !cfg.delivery_system;
        res.frequency           = cfg.tuned_frequency;
        res.terrestrial         = cfg.delivery_system;
    end

endmodule

`default_nettype wire

>>> sv/sdt_out_buffer.sv
// Two-entry result buffer between the parser and the m_ channel.
// Depends on sdt_pkg; room is taken from registered state only.
`default_nettype none

module sdt_out_buffer
    import sdt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_valid,
    input  wire sdt_result_t  wr_data,
    output logic              room,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output sdt_result_t       m_data
);

    sdt_result_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign room     = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_data   = entry_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr_valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for sdt_service_descriptor_parser_unit: SDT sections are fed as bytes,
// a scoreboard class walks the same sections and checks every service request that comes out.
// Depends on sdt_pkg and the parser top level only.

module testbench;
    import sdt_pkg::*;

    localparam int          HALF_PERIOD_NS       = 10;
    localparam int          TIMEOUT_NS           = 20_000_000;
    localparam int          SETTLE_CYCLES        = 6;
    localparam int          HOLD_CYCLES          = 300;
    localparam int          ITEMS_PER_PHASE      = 30;
    localparam int          RANDOM_PHASES        = 6;
    localparam int          MAX_REPORTS          = 40;
    localparam logic [11:0] SHORTEST_SECTION_LEN = 12'd17;
    localparam logic [11:0] LONGEST_SECTION_LEN  = 12'd1021;
    localparam logic [7:0]  ACTUAL_TS_TABLE_ID   = 8'h42;
    localparam logic [7:0]  SERVICE_DESCRIPTOR_TAG = 8'h48;
    localparam logic [7:0]  DIGITAL_TV_TYPE      = 8'h01;
    localparam int          CFG_FIRST_UNMAPPED   = 2;
    localparam int          CFG_LAST_INDEX       = 255;
    localparam logic [29:0] FREQ_TOP             = 30'd1_000_000_000;

    // tracks the section walk and holds the services still owed by the block
    class service_scoreboard;
        phase_t      phase;
        logic [11:0] byte_pos;
        logic [11:0] sec_len;
        logic [15:0] stream_id;
        logic [15:0] svc_number;
        logic [11:0] loop_left;
        logic [7:0]  offset;
        logic [7:0]  desc_len;
        bit          tag_hit;
        bit          terrestrial_cfg;
        logic [29:0] freq_cfg;
        sdt_result_t owed_services[$];
        int          mismatches;
        int          services_found;
        int          sections_started;

        function new();
            terrestrial_cfg  = 1'b0;
            freq_cfg         = '0;
            mismatches       = 0;
            services_found   = 0;
            sections_started = 0;
            restart();
            phase = PH_WAIT;
        endfunction

        function void restart();
            byte_pos   = '0;
            sec_len    = '0;
            stream_id  = '0;
            svc_number = '0;
            loop_left  = '0;
            offset     = '0;
            desc_len   = '0;
            tag_hit    = 1'b0;
        endfunction

        function int pending();
            return owed_services.size();
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_DELIVERY_SYSTEM)
                terrestrial_cfg = value[0];
            else if (idx == CFG_TUNED_FREQUENCY)
                freq_cfg = value[29:0];
        endfunction

        // one descriptor loop byte consumed, count saturates at zero
        function void use_loop_byte();
            if (loop_left != 0)
                loop_left = loop_left - 12'd1;
        endfunction

        // walk one accepted section byte, queue a service when one is found
        function void note_section_byte(logic [7:0] b, logic start);
            logic [11:0] pos;
            sdt_result_t svc;
            if (start) begin
                restart();
                phase = PH_HEADER;
                sections_started++;
            end
            if (phase == PH_WAIT || phase == PH_DONE)
                return;
            pos      = byte_pos;
            byte_pos = byte_pos + 12'd1;

            // fixed section header: length, stream id, loop starts after byte 10
            if (phase == PH_HEADER) begin
                case (pos)
                    12'd1: sec_len = {b[3:0], 8'h00};
                    12'd2: begin
                        sec_len[7:0] = b;
                        if (sec_len < SHORTEST_SECTION_LEN || sec_len > LONGEST_SECTION_LEN)
                            phase = PH_WAIT;
                    end
                    12'd3: stream_id = {b, 8'h00};
                    12'd4: stream_id[7:0] = b;
                    12'd10: begin
                        phase  = PH_SVC;
                        offset = '0;
                    end
                    default: ;
                endcase
                return;
            end

            // crc and anything past it
            if (pos >= sec_len - 12'd1) begin
                phase = PH_DONE;
                return;
            end

            case (phase)
                PH_SVC: begin
                    case (offset)
                        8'd0: svc_number = {b, 8'h00};
                        8'd1: svc_number[7:0] = b;
                        8'd3: loop_left = {b[3:0], 8'h00};
                        8'd4: loop_left[7:0] = b;
                        default: ;
                    endcase
                    if (offset >= 8'd4) begin
                        offset = '0;
                        if (loop_left != 0)
                            phase = PH_DTAG;
                    end else begin
                        offset = offset + 8'd1;
                    end
                end
                PH_DTAG: begin
                    tag_hit = (b == SERVICE_DESCRIPTOR_TAG);
                    use_loop_byte();
                    if (loop_left == 0) begin
                        phase  = PH_SVC;
                        offset = '0;
                    end else begin
                        phase = PH_DLEN;
                    end
                end
                PH_DLEN: begin
                    desc_len = b;
                    use_loop_byte();
                    offset = '0;
                    if (loop_left == 0)
                        phase = PH_SVC;
                    else if (b == 8'h00)
                        phase = PH_DTAG;
                    else
                        phase = PH_DBODY;
                end
                PH_DBODY: begin
                    // service type is the first body byte
                    if (offset == 0 && tag_hit && b == DIGITAL_TV_TYPE) begin
                        svc.service_number      = svc_number;
                        svc.stream_number       = terrestrial_cfg ? 16'h0000 : stream_id;
                        svc.stream_number_valid = !terrestrial_cfg;
                        svc.frequency           = freq_cfg;
                        svc.terrestrial         = terrestrial_cfg;
                        owed_services.push_back(svc);
                    end
                    offset = offset + 8'd1;
                    use_loop_byte();
                    if (loop_left == 0) begin
                        phase  = PH_SVC;
                        offset = '0;
                    end else if (offset >= desc_len) begin
                        phase  = PH_DTAG;
                        offset = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, should be %0h", field, got, want));
        endtask

        // compare one accepted service request with the oldest owed service
        task check_result(logic [RESULT_W-1:0] word);
            sdt_result_t want;
            if (owed_services.size() == 0) begin
                report_mismatch($sformatf("service request %h with none owed", word));
                return;
            end
            want = owed_services.pop_front();
            services_found++;
            compare_field("service_number", 32'(word[15:0]), 32'(want.service_number));
            compare_field("stream_number", 32'(word[31:16]), 32'(want.stream_number));
            compare_field("stream_number_valid", 32'(word[32]), 32'(want.stream_number_valid));
            compare_field("frequency", 32'(word[62:33]), 32'(want.frequency));
            compare_field("terrestrial", 32'(word[63]), 32'(want.terrestrial));
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [RESULT_W-1:0]    m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    service_scoreboard sb = new();
    logic [7:0]        section_q[$];
    bit                sender_steady  = 1'b0;
    bit                hold_request   = 1'b0;
    int                items_sent     = 0;
    int                input_stalls   = 0;
    int                configs_done   = 0;

    sdt_service_descriptor_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #HALF_PERIOD_NS aclk = 1'b1;
        #HALF_PERIOD_NS aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_cycles(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one section in section_q; a bent section may carry loop and section
    // lengths that disagree with its content, or be cut short
    function automatic void build_section(int services, int body_max, bit bent, int forced_len);
        logic [7:0]  body[$];
        logic [11:0] sec_len;
        logic [11:0] loop_len;
        int          hdr_at;
        int          n_desc;
        int          dlen;
        int          s;
        int          cut;
        s = 0;
        while (s < services || (forced_len != 0 && body.size() < forced_len - 12)) begin
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            hdr_at = body.size();
            body.push_back(8'h00);
            body.push_back(8'h00);
            n_desc = $urandom_range(0, 3);
            for (int d = 0; d < n_desc; d++) begin
                body.push_back(($urandom_range(0, 3) != 0) ? SERVICE_DESCRIPTOR_TAG
                                                            : 8'($urandom));
                dlen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, body_max);
                body.push_back(8'(dlen));
                for (int i = 0; i < dlen; i++)
                    body.push_back((i == 0 && $urandom_range(0, 3) != 0) ? DIGITAL_TV_TYPE
                                                                          : 8'($urandom));
            end
            loop_len = 12'(body.size() - hdr_at - 2);
            if (bent && $urandom_range(0, 3) == 0)
                loop_len = ($urandom_range(0, 1) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(0, loop_len + 6));
            body[hdr_at]     = {4'($urandom), loop_len[11:8]};
            body[hdr_at + 1] = loop_len[7:0];
            s++;
        end
        if (forced_len != 0) begin
            while (body.size() > forced_len - 12)
                void'(body.pop_back());
        end

        // section length counts from byte 3 through the crc
        sec_len = 12'(body.size() + 12);
        if (forced_len != 0) begin
            sec_len = 12'(forced_len);
        end else if (bent) begin
            case ($urandom_range(0, 3))
                0: sec_len = 12'($urandom_range(0, SHORTEST_SECTION_LEN - 1));
                1: sec_len = 12'($urandom_range(LONGEST_SECTION_LEN + 1, 4095));
                default: sec_len = sec_len + 12'($urandom_range(0, 12)) - 12'd6;
            endcase
        end

        section_q.delete();
        section_q.push_back(($urandom_range(0, 1) == 0) ? ACTUAL_TS_TABLE_ID : 8'($urandom));
        section_q.push_back({4'($urandom), sec_len[11:8]});
        section_q.push_back(sec_len[7:0]);
        repeat (8) section_q.push_back(8'($urandom));
        foreach (body[i])
            section_q.push_back(body[i]);
        repeat (4) section_q.push_back(8'($urandom));
        if (bent && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, section_q.size() - 1);
            while (section_q.size() > cut)
                void'(section_q.pop_back());
        end
    endfunction

    // one section byte request, then an optional gap
    task automatic send_byte(input logic [7:0] value, input logic start, input bit counted);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        sb.note_section_byte(value, start);
        if (counted)
            items_sent++;
        gap = idle_cycles(sender_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_section();
        foreach (section_q[i])
            send_byte(section_q[i], i == 0, 1'b1);
    endtask

    // stop sending and let every owed service come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_register(idx, value);
    endtask

    // new register setting, with a write to an unmapped index that must be dropped
    task automatic configure(input logic terrestrial, input logic [29:0] freq);
        cfg_write(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_INDEX)), $urandom);
        cfg_write(CFG_TUNED_FREQUENCY, CFG_DATA_W'(freq));
        cfg_write(CFG_DELIVERY_SYSTEM, CFG_DATA_W'(terrestrial));
        cfg_valid <= 1'b0;
        configs_done++;
    endtask

    // result side ready, with gaps, steady stretches and one long hold-off
    initial begin : result_sink
        int run;
        int gap;
        int held;
        bit steady;
        steady = 1'b0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
            m_tready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
            gap = idle_cycles(steady);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin : stimulus
        int  p;
        int  phase_start;
        int  dense_left;
        bit  long_sent;
        bit  bent;
        long_sent  = 1'b0;
        dense_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        configure(1'b0, 30'd0);

        // stray byte before any section start
        send_byte(8'hFF, 1'b0, 1'b1);
        // section length just under the lower bound, high nibble junk
        section_q = '{ACTUAL_TS_TABLE_ID, 8'h50, 8'h10};
        send_section();
        // section length just over the upper bound
        section_q = '{ACTUAL_TS_TABLE_ID, 8'h03, 8'hFE};
        send_section();
        // valid section cut off in its header by the next start
        section_q = '{ACTUAL_TS_TABLE_ID, 8'h00, 8'h20, 8'h00};
        send_section();
        // empty service descriptor, then one truncated by the loop end that still matches,
        // then the crc and a trailing byte
        section_q = '{ACTUAL_TS_TABLE_ID, 8'hF0, 8'h16, 8'hFF, 8'hFF, 8'hC1, 8'h00, 8'h00,
                      8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFC, 8'hF0, 8'h05,
                      SERVICE_DESCRIPTOR_TAG, 8'h00,
                      SERVICE_DESCRIPTOR_TAG, 8'h05, DIGITAL_TV_TYPE,
                      8'h12, 8'h34, 8'h56, 8'h78};
        send_section();
        send_byte(8'h00, 1'b0, 1'b1);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: configure(1'b1, FREQ_TOP);
                1: configure(1'b0, FREQ_TOP);
                2: configure(1'b1, 30'd0);
                default: configure(1'($urandom), 30'($urandom_range(0, FREQ_TOP)));
            endcase
            // hold the result side off while dense sections keep coming
            if (p == 1) begin
                hold_request = 1'b1;
                dense_left   = 6;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE || dense_left > 0) begin
                sender_steady = (dense_left > 0) || ($urandom_range(0, 3) == 0);
                bent = (dense_left == 0) && ($urandom_range(0, 99) < 25);
                if (p == 3 && !long_sent) begin
                    build_section(1, 12, 1'b0, LONGEST_SECTION_LEN);
                    long_sent = 1'b1;
                end else begin
                    build_section($urandom_range(1, 4), $urandom_range(1, 12), bent, 0);
                end
                send_section();
                if (dense_left > 0)
                    dense_left--;
                // noise that the block should mostly drop
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0);
                if ($urandom_range(0, 19) == 0)
                    send_byte(8'($urandom), 1'b1, 1'b0);
                // sender waits for every owed service now and then
                if (dense_left == 0 && $urandom_range(0, 11) == 0)
                    drain();
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d services never came out", sb.pending()));
        $display("Summary: %0d section bytes over %0d section starts, %0d services checked",
                 items_sent, sb.sections_started, sb.services_found);
        $display("Summary: %0d register settings, %0d cycles with the byte input stalled",
                 configs_done, input_stalls);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

    // overall limit
    initial begin : watchdog
        #TIMEOUT_NS;
        $display("run timed out, %0d services still owed", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule
